// File: hdl/sparse_column_list_to_dense_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse column list unit
// Short forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_LIST_TO_DENSE_UNIT_MACROS_SVH
`define SPARSE_COLUMN_LIST_TO_DENSE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define SCL2D_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scl2d: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define SCL2D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scl2d: next-cycle check failed");

`endif

// File: hdl/scl2d_pkg.sv
// ----------------------------------------------------------------------------
// scl2d_pkg
// Field widths, command codes and the control and status groups shared by
// the sparse column list unit and its entry scanner.
// ----------------------------------------------------------------------------
package scl2d_pkg;

	// Fixed field widths of the stream beats.
	localparam int FUNC_W      = 2;
	localparam int COL_W       = 3;
	localparam int ROW_W       = 3;
	localparam int IN_VALUE_W  = 32;
	localparam int OUT_VALUE_W = 32;
	localparam int COUNT_W     = 4;

	// Number of distinct column or row indexes the fields can address.
	localparam int INDEX_SPAN = 1 << COL_W;

	// Command codes carried in tuser.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_READ   = 2'd2
	} func_t;

	// Requests from the top level to the entry scanner.
	typedef struct packed {
		logic start;
		logic wr_en;
	} scan_ctl_t;

	// Completion report from the entry scanner.
	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

// File: hdl/sparse_column_list_to_dense_unit.sv
// ----------------------------------------------------------------------------
// sparse_column_list_to_dense_unit
// Sparse matrix in column list form answering dense element reads.
// ----------------------------------------------------------------------------
// One item is handled at a time. A clear, an append, an unused command or
// a read outside the matrix goes from the execute step straight to the push
// step, which loads its result beat into the output register. A read within
// the matrix walks the addressed column list through the single-port entry
// memory, one entry per cycle, with registered read data, until the first
// pair whose row matches or the end of the fill pairs in that column, at
// most DIM; its result beat is then loaded in the push step. The next beat
// is accepted as soon as the result sits in the output register, even if it
// has not been taken yet; a result beat that is still waiting there holds
// back the next load, and with it the input. No clearing pass is needed
// after reset: the per-column fill counts are cleared at once and entries
// beyond them are never read.
// ----------------------------------------------------------------------------
module sparse_column_list_to_dense_unit #(
	parameter int DIM        = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // column[2:0], row[5:3], value[37:6]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // read_value[31:0], nonzero_rows[35:32],
	                                    // status[36]
);
	import scl2d_pkg::*;

	`include "sparse_column_list_to_dense_unit_macros.svh"

	localparam int NCOL = (DIM < INDEX_SPAN) ? DIM : INDEX_SPAN;
	localparam int NROW = NCOL;
	localparam int CW   = $clog2(NCOL);
	localparam int RW   = $clog2(NROW);
	localparam int FW   = $clog2(DIM + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_PUSH = 4'b1000
	} state_t;

	state_t                  st_q;
	logic [FUNC_W-1:0]       req_func_q;
	logic [COL_W-1:0]        req_col_q;
	logic [ROW_W-1:0]        req_row_q;
	logic [IN_VALUE_W-1:0]   req_value_q;

	logic [FW-1:0]           fill_q [NCOL];
	logic [NROW-1:0]         row_seen_q;
	logic [COUNT_W-1:0]      row_count_q;

	logic [VALUE_BITS-1:0]   res_value_q;
	logic                    res_status_q;

	logic                    m_tvalid_q;
	logic [OUT_VALUE_W-1:0]  out_value_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic                    out_status_q;

	logic                    in_accept;
	logic                    out_free;
	logic                    in_range;
	logic [FW-1:0]           col_fill;
	logic                    col_full;
	logic [VALUE_BITS-1:0]   wr_value;
	logic                    wr_nonzero;
	scan_ctl_t               scan_ctl;
	scan_stat_t              scan_stat;
	logic [VALUE_BITS-1:0]   scan_value;

	// Stream handshakes.
	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {3'b000, out_status_q, out_count_q, out_value_q};

	// Decode of the held item.
	assign in_range   = (int'(req_col_q) < NCOL) && (int'(req_row_q) < NROW);
	assign col_fill   = fill_q[req_col_q[CW-1:0]];
	assign col_full   = (int'(col_fill) >= DIM);
	assign wr_value   = VALUE_BITS'(req_value_q);
	assign wr_nonzero = (wr_value != '0);

	// Scanner requests are issued from the execute step only.
	always_comb begin
		scan_ctl.start = 1'b0;
		scan_ctl.wr_en = 1'b0;
		if (st_q == ST_EXEC && in_range) begin
			if (req_func_q == FUNC_READ) begin
				scan_ctl.start = 1'b1;
			end
			if (req_func_q == FUNC_APPEND && !col_full) begin
				scan_ctl.wr_en = 1'b1;
			end
		end
	end

	scl2d_scan #(
		.DIM        (DIM),
		.VALUE_BITS (VALUE_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.col      (req_col_q),
		.row      (req_row_q),
		.fill     (col_fill),
		.wr_value (wr_value),
		.stat     (scan_stat),
		.rd_value (scan_value)
	);

	// Held item: taken from the input beat.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_func_q  <= s_axis_tuser;
			req_col_q   <= s_axis_tdata[2:0];
			req_row_q   <= s_axis_tdata[5:3];
			req_value_q <= s_axis_tdata[37:6];
		end
	end

	// Result of the item before it moves to the output register.
	always_ff @(posedge clk) begin
		if (st_q == ST_EXEC) begin
			res_value_q  <= '0;
			res_status_q <= (req_func_q == FUNC_APPEND) && in_range && col_full;
		end else if (st_q == ST_SCAN && scan_stat.done) begin
			res_value_q <= scan_stat.hit ? scan_value : '0;
		end
	end

	// Sequencer, list fills, seen-row marks and the nonzero-row count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			row_seen_q  <= '0;
			row_count_q <= '0;
			for (int c = 0; c < NCOL; c++) begin
				fill_q[c] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_accept) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					st_q <= ST_PUSH;
					case (req_func_q)
						FUNC_CLEAR: begin
							row_seen_q  <= '0;
							row_count_q <= '0;
							for (int c = 0; c < NCOL; c++) begin
								fill_q[c] <= '0;
							end
						end
						FUNC_APPEND: begin
							if (in_range && !col_full) begin
								fill_q[req_col_q[CW-1:0]] <= col_fill + 1'b1;
								if (wr_nonzero && !row_seen_q[req_row_q[RW-1:0]]) begin
									row_seen_q[req_row_q[RW-1:0]] <= 1'b1;
									row_count_q <= row_count_q + 1'b1;
								end
							end
						end
						FUNC_READ: begin
							if (in_range) begin
								st_q <= ST_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SCAN: begin
					if (scan_stat.done) begin
						st_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (st_q == ST_PUSH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_PUSH && out_free) begin
			out_value_q  <= OUT_VALUE_W'(res_value_q);
			out_count_q  <= row_count_q;
			out_status_q <= res_status_q;
		end
	end

	// Checks on the sequencing and the seen-row bookkeeping.
	`SCL2D_ASSERT_IMPLY(a_count_matches_marks, 1'b1, row_count_q == COUNT_W'($countones(row_seen_q)))
	`SCL2D_ASSERT_IMPLY(a_scan_only_for_read, st_q == ST_SCAN, req_func_q == FUNC_READ)
	`SCL2D_ASSERT_IMPLY(a_done_only_in_scan, scan_stat.done, st_q == ST_SCAN)
	`SCL2D_ASSERT_NEXT(a_accept_starts_exec, in_accept, st_q == ST_EXEC)

endmodule

// File: hdl/scl2d_scan.sv
// ----------------------------------------------------------------------------
// scl2d_scan
// Entry memory of all column lists with its append port and the scanner
// that walks one column list, one entry per cycle, for the first row match.
// ----------------------------------------------------------------------------
module scl2d_scan #(
	parameter int DIM        = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scl2d_pkg::scan_ctl_t          ctl,
	input  logic [scl2d_pkg::COL_W-1:0]   col,
	input  logic [scl2d_pkg::ROW_W-1:0]   row,
	input  logic [$clog2(DIM+1)-1:0]      fill,
	input  logic [VALUE_BITS-1:0]         wr_value,
	output scl2d_pkg::scan_stat_t         stat,
	output logic [VALUE_BITS-1:0]         rd_value
);
	import scl2d_pkg::*;

	localparam int NCOL   = (DIM < INDEX_SPAN) ? DIM : INDEX_SPAN;
	localparam int CW     = $clog2(NCOL);
	localparam int FW     = $clog2(DIM + 1);
	localparam int DEPTH  = NCOL * DIM;
	localparam int AW     = $clog2(DEPTH);
	localparam int WORD_W = ROW_W + VALUE_BITS;

	logic [WORD_W-1:0] entry_mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_s1;
	logic              rvalid_s1;
	logic              busy_q;
	logic [FW-1:0]     idx_q;

	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     mem_addr;
	logic              hit_now;
	logic              issue;
	logic              finish;

	// Entry k of column c sits at c*DIM+k.
	assign wr_addr  = AW'(int'(col[CW-1:0]) * DIM + int'(fill));
	assign rd_addr  = AW'(int'(col[CW-1:0]) * DIM + int'(idx_q));
	assign mem_addr = ctl.wr_en ? wr_addr : rd_addr;

	// The entry read last cycle is compared here; a match ends the walk and
	// keeps any further read from being issued.
	assign hit_now = rvalid_s1 && (rdata_s1[VALUE_BITS +: ROW_W] == row);
	assign issue   = busy_q && !hit_now && (idx_q < fill);
	assign finish  = busy_q && !issue && (hit_now || !rvalid_s1);

	assign stat.done = finish;
	assign stat.hit  = hit_now;
	assign rd_value  = hit_now ? rdata_s1[VALUE_BITS-1:0] : '0;

	// Single-port entry memory: appends write, the walk reads.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			entry_mem_q[mem_addr] <= {row, wr_value};
		end
		if (issue) begin
			rdata_s1 <= entry_mem_q[mem_addr];
		end
	end

	// Walk control: index of the next entry and the read-in-flight flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (ctl.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else begin
				if (finish) begin
					busy_q <= 1'b0;
				end
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: test/sparse_column_list_checker.sv
// ----------------------------------------------------------------------------
// sparse_column_list_checker
// Watches both stream channels of the sparse column list unit, keeps its own
// copy of the column lists, row marks and row count, works out the result
// beat owed for every accepted input beat and compares each result beat,
// field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module sparse_column_list_checker #(
	parameter int DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // column[2:0], row[5:3], value[37:6]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // read_value[31:0], nonzero_rows[35:32],
	                                    // status[36]
	output int          mismatches,
	output int          pending,
	output int          results_seen,
	output int          read_hits,
	output int          dropped_appends,
	output int          clears_seen
);

	import scl2d_pkg::*;

	// One result beat as the block should present it.
	typedef struct packed {
		logic [OUT_VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0]     nonzero_rows;
		logic                   status;
	} dense_result_t;

	// Shadow copy of the matrix: pair k of column c sits at [c][k].
	logic [ROW_W-1:0]      pair_row   [INDEX_SPAN][DIM];
	logic [IN_VALUE_W-1:0] pair_value [INDEX_SPAN][DIM];
	int                    list_fill  [INDEX_SPAN];
	logic                  row_marked [INDEX_SPAN];
	logic [COUNT_W-1:0]    marked_rows;

	dense_result_t owed_results[$];
	dense_result_t owed;
	dense_result_t seen;
	dense_result_t predicted;

	int mismatch_total;
	int result_total;
	int hit_total;
	int drop_total;
	int clear_total;

	// Empties every column list and forgets which rows were seen; the pairs
	// themselves stay where they are.
	function automatic void empty_lists();
		for (int c = 0; c < INDEX_SPAN; c++) begin
			list_fill[c]  = 0;
			row_marked[c] = 1'b0;
		end
		marked_rows = '0;
	endfunction

	// Applies one input beat to the shadow matrix and returns the result
	// beat that it should cause.
	function automatic dense_result_t apply_dense_access(
		input logic [FUNC_W-1:0]     func_bits,
		input logic [COL_W-1:0]      column,
		input logic [ROW_W-1:0]      row,
		input logic [IN_VALUE_W-1:0] value
	);
		dense_result_t r;
		func_t         func;
		logic          found;
		logic          in_range;
		r        = '0;
		func     = func_t'(func_bits);
		found    = 1'b0;
		in_range = (int'(column) < DIM) && (int'(row) < DIM);
		case (func)
			FUNC_CLEAR: begin
				empty_lists();
				clear_total++;
			end
			FUNC_APPEND: begin
				// A column or row outside the matrix leaves everything as is.
				if (in_range && list_fill[column] >= DIM) begin
					r.status = 1'b1;
					drop_total++;
				end else if (in_range) begin
					pair_row[column][list_fill[column]]   = row;
					pair_value[column][list_fill[column]] = value;
					list_fill[column]++;
					// Only a nonzero value marks its row, and only once.
					if (value != '0 && !row_marked[row]) begin
						row_marked[row] = 1'b1;
						marked_rows++;
					end
				end
			end
			FUNC_READ: begin
				// The earliest pair with a matching row wins.
				for (int k = 0; in_range && k < list_fill[column] && k < DIM; k++) begin
					if (!found && pair_row[column][k] == row) begin
						r.read_value = pair_value[column][k];
						found        = 1'b1;
					end
				end
				if (found)
					hit_total++;
			end
			default: begin
			end
		endcase
		r.nonzero_rows = marked_rows;
		return r;
	endfunction

	// Result beats are checked before the input beat of the same edge is
	// predicted, since a result can never belong to a beat taken that edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_lists();
			owed_results.delete();
			mismatch_total  = 0;
			result_total    = 0;
			hit_total       = 0;
			drop_total      = 0;
			clear_total     = 0;
			mismatches      <= 0;
			pending         <= 0;
			results_seen    <= 0;
			read_hits       <= 0;
			dropped_appends <= 0;
			clears_seen     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.read_value   = m_axis_tdata[31:0];
				seen.nonzero_rows = m_axis_tdata[35:32];
				seen.status       = m_axis_tdata[36];
				result_total++;
				if (owed_results.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= 10)
						$display("Unexpected result beat %0d: value %h rows %0d status %0d",
							result_total, seen.read_value, seen.nonzero_rows, seen.status);
				end else begin
					owed = owed_results.pop_front();
					if (seen.read_value != owed.read_value
						|| seen.nonzero_rows != owed.nonzero_rows
						|| seen.status != owed.status) begin
						mismatch_total++;
						if (mismatch_total <= 10)
							$display({"Mismatch on result beat %0d: expected value %h ",
								"rows %0d status %0d, got value %h rows %0d status %0d"},
								result_total, owed.read_value, owed.nonzero_rows,
								owed.status, seen.read_value, seen.nonzero_rows, seen.status);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = apply_dense_access(s_axis_tuser,
					s_axis_tdata[2:0], s_axis_tdata[5:3], s_axis_tdata[37:6]);
				owed_results.insert(owed_results.size(), predicted);
			end
			mismatches      <= mismatch_total;
			pending         <= owed_results.size();
			results_seen    <= result_total;
			read_hits       <= hit_total;
			dropped_appends <= drop_total;
			clears_seen     <= clear_total;
		end
	end

endmodule

// File: test/tb_sparse_column_list_to_dense_unit.sv
// ----------------------------------------------------------------------------
// tb_sparse_column_list_to_dense_unit
// Stimulus and verdict for the sparse column list unit.
// ----------------------------------------------------------------------------
// A directed opening covers value extremes, zero and duplicate appends, a
// column filled past its depth, an unused command and a clear. Random beats
// follow, biased towards two columns so that lists fill up and drop pairs,
// with both channels stalling in random bursts until the closing stretch.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_sparse_column_list_to_dense_unit;

	import scl2d_pkg::*;

	localparam int DIM          = 8;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CALM_ITEMS   = 150;
	localparam int LIMIT_CYCLES = 400000;

	// Command code that the block does not use.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // column[2:0], row[5:3], value[37:6]
	logic [1:0]  s_axis_tuser;   // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // read_value[31:0], nonzero_rows[35:32],
	                             // status[36]

	int mismatches;
	int pending;
	int results_seen;
	int read_hits;
	int dropped_appends;
	int clears_seen;

	bit calm;
	bit halfway_drained;
	int counted;
	int pick;

	always #5 clk = ~clk;

	sparse_column_list_to_dense_unit #(
		.DIM        (DIM),
		.VALUE_BITS (32)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	sparse_column_list_checker #(
		.DIM (DIM)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_seen    (results_seen),
		.read_hits       (read_hits),
		.dropped_appends (dropped_appends),
		.clears_seen     (clears_seen)
	);

	// Offers one beat and holds it until taken, then now and again leaves a
	// gap before the next one.
	task automatic send_beat(
		input logic [FUNC_W-1:0]     func,
		input logic [COL_W-1:0]      column,
		input logic [ROW_W-1:0]      row,
		input logic [IN_VALUE_W-1:0] value
	);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {2'b00, value, row, column};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (!calm && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stops sending until every owed result beat has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Values lean towards the extremes, zero and small numbers.
	function automatic logic [IN_VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 32'h7fff_ffff;
			2:       return 32'h8000_0000;
			3:       return 32'hffff_ffff;
			4:       return 32'($urandom_range(1, 15));
			default: return $urandom;
		endcase
	endfunction

	// Half the beats go to the first two columns so that their lists fill up.
	function automatic logic [COL_W-1:0] pick_column();
		if ($urandom_range(0, 1))
			return COL_W'($urandom_range(0, 1));
		return COL_W'($urandom_range(0, INDEX_SPAN - 1));
	endfunction

	// Result side: stalls in random bursts, always ready in the calm stretch.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 99) < 15) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#(LIMIT_CYCLES * 10);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		calm            = 1'b0;
		halfway_drained = 1'b0;
		arst_n          <= 1'b0;
		s_axis_tvalid   <= 1'b0;
		s_axis_tdata    <= '0;
		s_axis_tuser    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read of an empty list, extremes, a zero and a duplicate row.
		send_beat(FUNC_READ, 3'd0, 3'd0, 32'h1234_5678);
		send_beat(FUNC_APPEND, 3'd0, 3'd0, 32'h7fff_ffff);
		send_beat(FUNC_APPEND, 3'd0, 3'd7, 32'h8000_0000);
		send_beat(FUNC_APPEND, 3'd0, 3'd3, 32'h0000_0000);
		send_beat(FUNC_APPEND, 3'd0, 3'd0, 32'hffff_ffff);
		send_beat(FUNC_READ, 3'd0, 3'd0, 32'hffff_ffff);
		send_beat(FUNC_READ, 3'd0, 3'd7, 32'h0000_0000);
		send_beat(FUNC_READ, 3'd0, 3'd3, 32'h0000_0000);
		send_beat(FUNC_READ, 3'd0, 3'd5, 32'h0000_0000);

		// Fill the last column to its depth, then one pair more is dropped.
		for (int k = 0; k < DIM; k++)
			send_beat(FUNC_APPEND, 3'd7, ROW_W'(DIM - 1 - k),
				(k % 2) ? -32'(k + 1) : 32'(k + 1));
		send_beat(FUNC_APPEND, 3'd7, 3'd2, 32'h5555_aaaa);
		send_beat(FUNC_READ, 3'd7, 3'd0, 32'h0000_0000);

		// Unused command, then a clear and reuse of the emptied lists.
		send_beat(FUNC_UNUSED, 3'd5, 3'd6, 32'hdead_beef);
		send_beat(FUNC_CLEAR, 3'd2, 3'd4, 32'h0f0f_0f0f);
		send_beat(FUNC_READ, 3'd0, 3'd0, 32'h0000_0000);
		send_beat(FUNC_APPEND, 3'd7, 3'd1, 32'h0000_0001);
		drain_results();

		// Random part: mostly appends and reads, with the odd clear.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm = (counted >= RANDOM_ITEMS - CALM_ITEMS);
			if (!halfway_drained && counted >= RANDOM_ITEMS / 2) begin
				halfway_drained = 1'b1;
				drain_results();
			end
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				send_beat(FUNC_CLEAR, pick_column(), ROW_W'($urandom_range(0, 7)), $urandom);
				counted++;
			end else if (pick < 4) begin
				send_beat(FUNC_UNUSED, pick_column(), ROW_W'($urandom_range(0, 7)), $urandom);
			end else if (pick < 52) begin
				send_beat(FUNC_APPEND, pick_column(), ROW_W'($urandom_range(0, 7)),
					pick_value());
				counted++;
			end else begin
				send_beat(FUNC_READ, pick_column(), ROW_W'($urandom_range(0, 7)), $urandom);
				counted++;
			end
		end

		// Let every owed result come back, then allow for a slow read.
		drain_results();
		repeat (DIM + 8) @(posedge clk);

		$display("Checked %0d result beats: %0d reads found a stored pair, %0d appends dropped,",
			results_seen, read_hits, dropped_appends);
		$display("%0d clears, %0d mismatches, %0d results still owed.",
			clears_seen, mismatches, pending);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/scl2d_pkg.sv
hdl/scl2d_scan.sv
hdl/sparse_column_list_to_dense_unit.sv
test/sparse_column_list_checker.sv
test/tb_sparse_column_list_to_dense_unit.sv
